// ===== rtl/core/pdl_pkg.sv =====
// Package for the pixel-doubling letterbox frame writer.
// Holds widths, request and register codes, payload structs and the color conversion.
// No dependencies; every other RTL file imports it.
`default_nettype none

package pdl_pkg;

  // Field widths
  localparam int ROW_W   = 9;
  localparam int PAIR_W  = 9;
  localparam int PIX_W   = 16;
  localparam int DATA_W  = 2 * PIX_W;
  localparam int SRCW_W  = 9;
  localparam int SRCH_W  = 8;
  localparam int SCRH_W  = 9;
  localparam int REQ_W   = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 9;

  // Pairs written per fill row (one full 640-pixel row)
  localparam logic [PAIR_W-1:0] FILL_PAIRS = 9'd320;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FILL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_SCR_HEIGHT = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_RGB565     = 2'd3;

  // Configuration register values
  typedef struct packed {
    logic [SRCW_W-1:0] src_width;
    logic [SRCH_W-1:0] src_height;
    logic [SCRH_W-1:0] screen_height;
    logic              rgb565_mode;
  } pdl_cfg_t;

  // One result as handed to the output stage; dual asks for a second
  // result on the next row with the same pair and data.
  typedef struct packed {
    logic              write_enable;
    logic [ROW_W-1:0]  dest_row;
    logic [PAIR_W-1:0] dest_pair;
    logic [DATA_W-1:0] pair_data;
    logic              misplaced;
    logic              last;
    logic              dual;
  } pdl_res_t;

  // RGB555 to RGB565: blue stays, red/green move up one, bit 15 dropped
  function automatic logic [PIX_W-1:0] rgb555_to_565(input logic [PIX_W-1:0] pix);
    return {pix[14:5], 1'b0, pix[4:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pdl_if.sv =====
// Stream interfaces for the frame writer: request channel and surface write channel.
// Depend on pdl_pkg for field widths.
`default_nettype none

interface pdl_in_if import pdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PIX_W-1:0]  pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface pdl_out_if import pdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [ROW_W-1:0]  dest_row;
  logic [PAIR_W-1:0] dest_pair;
  logic [DATA_W-1:0] pair_data;
  logic              misplaced;
  logic              last;

  modport source (output valid, output write_enable, output dest_row, output dest_pair,
                  output pair_data, output misplaced, output last, input ready);
  modport sink   (input valid, input write_enable, input dest_row, input dest_pair,
                  input pair_data, input misplaced, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pdl_cfg_regs.sv =====
// Configuration register file of the frame writer: write-only, decoded by index.
// Depends on pdl_pkg.
`default_nettype none

module pdl_cfg_regs import pdl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_wdata,
  output pdl_cfg_t               cfg
);

  pdl_cfg_t cfg_r;
  pdl_cfg_t cfg_nxt;

  // Index decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  cfg_nxt.src_width     = cfg_wdata[SRCW_W-1:0];
        CFG_SRC_HEIGHT: cfg_nxt.src_height    = cfg_wdata[SRCH_W-1:0];
        CFG_SCR_HEIGHT: cfg_nxt.screen_height = cfg_wdata[SCRH_W-1:0];
        CFG_RGB565:     cfg_nxt.rgb565_mode   = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width     <= 9'd320;
      cfg_r.src_height    <= 8'd240;
      cfg_r.screen_height <= 9'd480;
      cfg_r.rgb565_mode   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/pdl_frame_ctl.sv =====
// Frame sequencer: input register, phase/cursor state and per-item result logic.
// Depends on pdl_pkg and pdl_in_if; feeds pdl_out_stage.
`default_nettype none

module pdl_frame_ctl import pdl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pdl_cfg_t  cfg,
  pdl_in_if.sink         in_ch,
  input  wire logic      take,
  output logic           load,
  output pdl_res_t       res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TOP,
    PH_PIX,
    PH_BOT
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [ROW_W-1:0] row;
  } enter_t;

  // Input register
  logic              in_valid_r;
  logic [REQ_W-1:0]  req_r;
  logic [PIX_W-1:0]  pix_r;

  // Frame state
  phase_t            phase_r, phase_nxt;
  logic [ROW_W-1:0]  top_rows_r, top_rows_nxt;
  logic [ROW_W-1:0]  bot_rows_r, bot_rows_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [PAIR_W-1:0] cur_pair_r, cur_pair_nxt;
  logic [ROW_W-1:0]  rows_done_r, rows_done_nxt;

  logic              advance;
  logic [ROW_W:0]    gap;
  logic              gap_pos;
  logic [ROW_W-1:0]  top_new;
  logic [ROW_W-1:0]  bot_new;
  logic [PAIR_W-1:0] pair_inc;
  logic [ROW_W-1:0]  rd_inc;
  logic [PIX_W-1:0]  pix_conv;
  enter_t            ent;

  // First phase at or after 'from' that has work; from is never idle
  function automatic enter_t enter_phase(
    input phase_t            from,
    input logic [ROW_W-1:0]  top,
    input logic [ROW_W-1:0]  bot,
    input logic [SRCH_W-1:0] hgt,
    input logic [SRCW_W-1:0] wid,
    input logic [ROW_W-1:0]  row_in
  );
    enter_t e;
    e.row   = row_in;
    e.phase = PH_IDLE;
    if (from == PH_TOP && top != '0) begin
      e.phase = PH_TOP;
    end else if (from != PH_BOT && hgt != '0 && wid != '0) begin
      e.phase = PH_PIX;
      e.row   = top;
    end else begin
      e.row   = top + {hgt, 1'b0};
      e.phase = (bot != '0) ? PH_BOT : PH_IDLE;
    end
    return e;
  endfunction

  assign advance     = in_valid_r && take;
  assign in_ch.ready = !in_valid_r || take;
  assign load        = advance;

  // Letterbox split of the spare height
  assign gap     = {1'b0, cfg.screen_height} - {1'b0, cfg.src_height, 1'b0};
  assign gap_pos = !gap[ROW_W] && (gap != '0);
  assign top_new = gap_pos ? {1'b0, gap[ROW_W-1:1]} : '0;
  assign bot_new = gap_pos ? (gap[ROW_W-1:0] - top_new) : '0;

  assign pair_inc = cur_pair_r + 9'd1;
  assign rd_inc   = rows_done_r + 9'd1;
  assign pix_conv = cfg.rgb565_mode ? rgb555_to_565(pix_r) : pix_r;

  // Per-item result and state update
  always_comb begin
    phase_nxt     = phase_r;
    top_rows_nxt  = top_rows_r;
    bot_rows_nxt  = bot_rows_r;
    cur_row_nxt   = cur_row_r;
    cur_pair_nxt  = cur_pair_r;
    rows_done_nxt = rows_done_r;
    ent           = '{phase: PH_IDLE, row: '0};
    res           = '0;
    res.last      = 1'b1;

    unique case (req_r)
      REQ_START: begin
        if (phase_r != PH_IDLE) begin
          res.misplaced = 1'b1;
        end else begin
          top_rows_nxt  = top_new;
          bot_rows_nxt  = bot_new;
          ent           = enter_phase(PH_TOP, top_new, bot_new, cfg.src_height,
                                      cfg.src_width, '0);
          phase_nxt     = ent.phase;
          cur_row_nxt   = ent.row;
          cur_pair_nxt  = '0;
          rows_done_nxt = '0;
        end
      end
      REQ_PIXEL: begin
        if (phase_r != PH_PIX) begin
          res.misplaced = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.dest_row     = cur_row_r;
          res.dest_pair    = cur_pair_r;
          res.pair_data    = {pix_conv, pix_conv};
          res.last         = 1'b0;
          res.dual         = 1'b1;
          cur_pair_nxt     = pair_inc;
          if (pair_inc >= cfg.src_width) begin
            cur_pair_nxt  = '0;
            cur_row_nxt   = cur_row_r + 9'd2;
            rows_done_nxt = rd_inc;
            if (rd_inc >= {1'b0, cfg.src_height}) begin
              ent           = enter_phase(PH_BOT, top_rows_r, bot_rows_r, cfg.src_height,
                                          cfg.src_width, cur_row_r);
              phase_nxt     = ent.phase;
              cur_row_nxt   = ent.row;
              rows_done_nxt = '0;
            end
          end
        end
      end
      REQ_FILL: begin
        if (phase_r != PH_TOP && phase_r != PH_BOT) begin
          res.misplaced = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.dest_row     = cur_row_r;
          res.dest_pair    = cur_pair_r;
          cur_pair_nxt     = pair_inc;
          if (pair_inc >= FILL_PAIRS) begin
            cur_pair_nxt  = '0;
            cur_row_nxt   = cur_row_r + 9'd1;
            rows_done_nxt = rd_inc;
            if (phase_r == PH_TOP && rd_inc >= top_rows_r) begin
              ent           = enter_phase(PH_PIX, top_rows_r, bot_rows_r, cfg.src_height,
                                          cfg.src_width, cur_row_nxt);
              phase_nxt     = ent.phase;
              cur_row_nxt   = ent.row;
              rows_done_nxt = '0;
            end else if (phase_r == PH_BOT && rd_inc >= bot_rows_r) begin
              phase_nxt     = PH_IDLE;
              rows_done_nxt = '0;
            end
          end
        end
      end
      default: begin
        res.misplaced = 1'b1;
      end
    endcase
  end

  // Input register: takes a transfer whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.req_type;
      pix_r <= in_ch.pixel;
    end
  end

  // Frame state, updated as each item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      top_rows_r  <= '0;
      bot_rows_r  <= '0;
      cur_row_r   <= '0;
      cur_pair_r  <= '0;
      rows_done_r <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      top_rows_r  <= top_rows_nxt;
      bot_rows_r  <= bot_rows_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_pair_r  <= cur_pair_nxt;
      rows_done_r <= rows_done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pdl_out_stage.sv =====
// Result register of the frame writer; expands a pixel into its two row writes.
// Depends on pdl_pkg and pdl_out_if.
`default_nettype none

module pdl_out_stage import pdl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire pdl_res_t  res,
  output logic           take,
  pdl_out_if.source      out_ch
);

  logic     out_valid_r, out_valid_nxt;
  pdl_res_t res_r, res_nxt;
  logic     xfer;

  assign xfer = out_valid_r && out_ch.ready;
  // Free for a new result once the current one leaves and no second row waits
  assign take = !out_valid_r || (out_ch.ready && !res_r.dual);

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (xfer) begin
      if (res_r.dual) begin
        // second row of a pixel pair
        res_nxt.dest_row = res_r.dest_row + 9'd1;
        res_nxt.last     = 1'b1;
        res_nxt.dual     = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_enable = res_r.write_enable;
  assign out_ch.dest_row     = res_r.dest_row;
  assign out_ch.dest_pair    = res_r.dest_pair;
  assign out_ch.pair_data    = res_r.pair_data;
  assign out_ch.misplaced    = res_r.misplaced;
  assign out_ch.last         = res_r.last;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_doubler_letterbox_rgb555_to_565_top.sv =====
// Top level of the 2x pixel-doubling letterbox frame writer (RGB555 to RGB565).
// Instantiates pdl_cfg_regs, pdl_frame_ctl and pdl_out_stage; uses pdl_pkg and pdl_if.
//
// A frame start item splits the spare screen height into top and bottom black
// bands; fill items write one black pair each (320 pairs per row), and each
// source pixel becomes one pair written on two adjacent rows. Items that do
// not fit the current phase return one result flagged misplaced. An item passes
// from the input register into the result register, which holds its first
// result. Start and fill items sustain one per cycle while the result channel
// is ready; a pixel holds the single result register for both of its row
// writes. No clearing pass after reset. The user must make configuration writes
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module pixel_doubler_letterbox_rgb555_to_565_top import pdl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_wdata,
  pdl_in_if.sink                 in_ch,
  pdl_out_if.source              out_ch
);

  pdl_cfg_t cfg;
  pdl_res_t res;
  logic     load;
  logic     take;

  pdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdl_frame_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .in_ch (in_ch),
    .take  (take),
    .load  (load),
    .res   (res)
  );

  pdl_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .res    (res),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the 2x pixel-doubling letterbox frame writer (RGB555 to RGB565).
// Drives requests and register writes, predicts every surface write in-line and checks
// each transfer on the result channel. Needs pdl_pkg, pdl_if and the top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdl_pkg::*;

  // Request code the block does not define
  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
  localparam int RANDOM_ITEMS = 1150;

  typedef enum logic [1:0] {PH_IDLE, PH_TOP_BAND, PH_PICTURE, PH_BOTTOM_BAND} frame_phase_t;

  typedef struct packed {
    logic              write_enable;
    logic [ROW_W-1:0]  dest_row;
    logic [PAIR_W-1:0] dest_pair;
    logic [DATA_W-1:0] pair_data;
    logic              misplaced;
    logic              last;
  } surface_write_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_wdata;

  pdl_in_if  in_ch ();
  pdl_out_if out_ch ();

  pixel_doubler_letterbox_rgb555_to_565_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  // Mirror of the frame writer: settings, phase and write cursor
  logic [SRCW_W-1:0] pic_width;
  logic [SRCH_W-1:0] pic_height;
  logic [SCRH_W-1:0] screen_rows;
  logic              convert_565;
  frame_phase_t      phase_now;
  logic [ROW_W-1:0]  top_band, bottom_band, row_cursor, rows_finished;
  logic [PAIR_W-1:0] pair_cursor;

  surface_write_t expected_writes[$];
  surface_write_t want;

  int  items_sent, frames_started, writes_seen, flagged_seen, mismatches;
  int  calm_after = 32'h7fffffff;
  bit  sender_idling = 1'b1;
  bit  sink_idling = 1'b1;
  bit  calm_tail = 1'b0;

  function automatic void push_write(input logic we, input logic [ROW_W-1:0] row,
                                     input logic [PAIR_W-1:0] pair,
                                     input logic [DATA_W-1:0] data, input logic mis,
                                     input logic last);
    expected_writes.push_back('{we, row, pair, data, mis, last});
  endfunction

  // Move to the first phase from 'from' on that has work; past the end means idle
  function automatic void open_phase(input frame_phase_t from);
    frame_phase_t ph;
    ph = from;
    rows_finished = '0;
    pair_cursor = '0;
    if (ph == PH_TOP_BAND && top_band == 0) ph = PH_PICTURE;
    if (ph == PH_PICTURE && (pic_height == 0 || pic_width == 0)) ph = PH_BOTTOM_BAND;
    if (ph == PH_BOTTOM_BAND && bottom_band == 0) ph = PH_IDLE;
    // picture sits under the top band; bottom band (or parked cursor) under the picture
    if (ph == PH_PICTURE) begin
      row_cursor = top_band;
    end else if (ph != PH_TOP_BAND) begin
      row_cursor = ROW_W'(top_band + 2 * pic_height);
    end
    phase_now = ph;
  endfunction

  // Works out the surface writes one accepted request causes
  function automatic void predict_surface_writes(input logic [REQ_W-1:0] rt,
                                                 input logic [PIX_W-1:0] px);
    int gap, top_share, bottom_share;
    logic [PIX_W-1:0]  shade;
    logic [ROW_W-1:0]  row;
    logic [PAIR_W-1:0] pair;
    row = row_cursor;
    pair = pair_cursor;
    case (rt)
      REQ_START: begin
        if (phase_now != PH_IDLE) begin
          push_write(1'b0, '0, '0, '0, 1'b1, 1'b1);
        end else begin
          // spare height: truncated half on top, rest below, negative shares are empty
          gap = int'(screen_rows) - 2 * int'(pic_height);
          top_share = gap / 2;
          bottom_share = gap - top_share;
          top_band = (top_share > 0) ? ROW_W'(top_share) : '0;
          bottom_band = (bottom_share > 0) ? ROW_W'(bottom_share) : '0;
          row_cursor = '0;
          frames_started++;
          open_phase(PH_TOP_BAND);
          push_write(1'b0, '0, '0, '0, 1'b0, 1'b1);
        end
      end
      REQ_PIXEL: begin
        if (phase_now != PH_PICTURE) begin
          push_write(1'b0, '0, '0, '0, 1'b1, 1'b1);
        end else begin
          // 565: red and green move up a bit, green LSB zero, bit 15 dropped
          shade = convert_565 ? (PIX_W'((px & 16'h7FE0) << 1) | (px & 16'h001F)) : px;
          push_write(1'b1, row, pair, {shade, shade}, 1'b0, 1'b0);
          push_write(1'b1, row + 1'b1, pair, {shade, shade}, 1'b0, 1'b1);
          pair_cursor = pair_cursor + 1'b1;
          if (pair_cursor >= pic_width) begin
            pair_cursor = '0;
            row_cursor = row_cursor + 2'd2;
            rows_finished = rows_finished + 1'b1;
            if (rows_finished >= pic_height) open_phase(PH_BOTTOM_BAND);
          end
        end
      end
      REQ_FILL: begin
        if (phase_now != PH_TOP_BAND && phase_now != PH_BOTTOM_BAND) begin
          push_write(1'b0, '0, '0, '0, 1'b1, 1'b1);
        end else begin
          push_write(1'b1, row, pair, '0, 1'b0, 1'b1);
          pair_cursor = pair_cursor + 1'b1;
          if (pair_cursor >= FILL_PAIRS) begin
            pair_cursor = '0;
            row_cursor = row_cursor + 1'b1;
            rows_finished = rows_finished + 1'b1;
            if (phase_now == PH_TOP_BAND && rows_finished >= top_band) begin
              open_phase(PH_PICTURE);
            end else if (phase_now == PH_BOTTOM_BAND && rows_finished >= bottom_band) begin
              phase_now = PH_IDLE;
              rows_finished = '0;
            end
          end
        end
      end
      default: push_write(1'b0, '0, '0, '0, 1'b1, 1'b1);
    endcase
  endfunction

  // Request side: optional gap, then hold the item until the transfer
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [PIX_W-1:0] px);
    int gap;
    @(negedge clk);
    if (sender_idling && !calm_tail && $urandom_range(5) == 0) begin
      gap = $urandom_range(8, 1);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = rt;
    in_ch.pixel    = px;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_surface_writes(rt, px);
    items_sent++;
    if (items_sent >= calm_after) calm_tail = 1'b1;
  endtask

  // Drop valid and wait until every expected write has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFGI_W-1:0] idx, input int value);
    wait_for_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFGD_W'(value);
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  pic_width   = cfg_wdata[SRCW_W-1:0];
      CFG_SRC_HEIGHT: pic_height  = cfg_wdata[SRCH_W-1:0];
      CFG_SCR_HEIGHT: screen_rows = cfg_wdata[SCRH_W-1:0];
      CFG_RGB565:     convert_565 = cfg_wdata[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input int scr, input bit mode);
    set_reg(CFG_SRC_WIDTH, w);
    set_reg(CFG_SRC_HEIGHT, h);
    set_reg(CFG_SCR_HEIGHT, scr);
    set_reg(CFG_RGB565, mode);
  endtask

  // Reset settings: 320x240 on 480 rows, so no band; pass-through pixels
  task automatic test_reset_config_frame();
    send_request(REQ_START, 16'h0000);
    send_request(REQ_PIXEL, 16'h0000);
    send_request(REQ_PIXEL, 16'hFFFF);
    send_request(REQ_PIXEL, 16'h8000);
    send_request(REQ_PIXEL, 16'h7FFF);
    // wrong-phase items inside the picture
    send_request(REQ_FILL, 16'hFFFF);
    send_request(REQ_START, 16'h1234);
    send_request(REQ_UNDEF, 16'hA5A5);
  endtask

  // Shrinking width and height mid-picture: the >= compares end the frame
  task automatic test_midframe_resize();
    set_reg(CFG_SRC_WIDTH, 1);
    set_reg(CFG_SRC_HEIGHT, 1);
    send_request(REQ_PIXEL, 16'h5555);
    send_request(REQ_PIXEL, 16'hAAAA);
  endtask

  task automatic test_rgb565_conversion();
    set_frame(4, 1, 0, 1'b1);
    send_request(REQ_START, 16'hFFFF);
    send_request(REQ_PIXEL, 16'hFFFF);
    send_request(REQ_PIXEL, 16'h8000);
    send_request(REQ_PIXEL, 16'h001F);
    send_request(REQ_PIXEL, 16'h7FE0);
    // frame done: everything but a start is flagged in idle
    send_request(REQ_PIXEL, 16'h3C3C);
    send_request(REQ_FILL, 16'h0000);
    send_request(REQ_UNDEF, 16'hFFFF);
  endtask

  // Odd negative spare height: both shares negative, no bands
  task automatic test_negative_gap();
    set_frame(1, 3, 1, 1'b0);
    send_request(REQ_START, 16'($urandom));
    repeat (3) send_request(REQ_PIXEL, 16'($urandom));
  endtask

  // Nothing to draw at all: the start goes straight back to idle
  task automatic test_empty_picture();
    set_frame(0, 0, 0, 1'b1);
    send_request(REQ_START, 16'h0F0F);
    send_request(REQ_START, 16'hF0F0);
  endtask

  // One frame: settings, some idle noise, then mostly the item the phase wants
  task automatic run_frame(input int w, input int h, input int scr, input bit mode);
    logic [REQ_W-1:0] rt;
    set_frame(w, h, scr, mode);
    sender_idling = ($urandom_range(3) != 0);
    sink_idling   = ($urandom_range(3) != 0);
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        rt = $urandom_range(1) ? REQ_FILL : REQ_PIXEL;
        if ($urandom_range(2) == 0) rt = REQ_UNDEF;
        send_request(rt, 16'($urandom));
      end
    end
    send_request(REQ_START, 16'($urandom));
    while (phase_now != PH_IDLE) begin
      if ($urandom_range(15) == 0) rt = REQ_W'($urandom_range(3));
      else rt = (phase_now == PH_PICTURE) ? REQ_PIXEL : REQ_FILL;
      send_request(rt, 16'($urandom));
    end
  endtask

  task automatic test_random_frames();
    int base, k, w, h, r, scr;
    base = items_sent;
    calm_after = base + RANDOM_ITEMS - 150;
    k = 0;
    while (k <= 6 || items_sent - base < RANDOM_ITEMS) begin
      if (k == 0) begin
        // one black row above and one below a one-row picture
        w = $urandom_range(3, 1);
        h = 1;
        scr = 4;
      end else if (k == 3) begin
        // empty picture still takes its rows: bottom band starts under them
        w = 0;
        h = $urandom_range(4, 1);
        scr = 2 * h + 1;
      end else if (k == 6) begin
        w = 1;
        h = 240;
        scr = 480;
      end else begin
        w = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(7);
        h = $urandom_range(4);
        r = $urandom_range(7);
        scr = (2 * h > r) ? 2 * h - r : 0;
      end
      run_frame(w, h, scr, $urandom_range(1));
      k++;
    end
  endtask

  // Result side: random stall bursts, none in the calm tail
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_idling && !calm_tail && $urandom_range(7) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(7);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 100) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
    end
  endfunction

  // Each result transfer against the oldest expected write
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.write_enable) writes_seen++;
      if (out_ch.misplaced) flagged_seen++;
      if (expected_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual row %0d pair %0d data %0h",
                 $time, out_ch.dest_row, out_ch.dest_pair, out_ch.pair_data);
      end else begin
        want = expected_writes.pop_front();
        check_field("write_enable", want.write_enable, out_ch.write_enable);
        check_field("dest_row", want.dest_row, out_ch.dest_row);
        check_field("dest_pair", want.dest_pair, out_ch.dest_pair);
        check_field("pair_data", want.pair_data, out_ch.pair_data);
        check_field("misplaced", want.misplaced, out_ch.misplaced);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: timeout with %0d writes outstanding", expected_writes.size());
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SRC_WIDTH;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_START;
    in_ch.pixel    = '0;
    pic_width      = 9'd320;
    pic_height     = 8'd240;
    screen_rows    = 9'd480;
    convert_565    = 1'b0;
    phase_now      = PH_IDLE;
    top_band       = '0;
    bottom_band    = '0;
    row_cursor     = '0;
    rows_finished  = '0;
    pair_cursor    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_config_frame();
    test_midframe_resize();
    test_rgb565_conversion();
    test_negative_gap();
    test_empty_picture();
    test_random_frames();

    wait_for_drain();
    repeat (6) @(posedge clk);
    $display("tb: %0d requests over %0d frames, incl. bands, empty and 240-row pictures",
             items_sent, frames_started);
    $display("tb: %0d surface writes and %0d flagged items checked, %0d mismatches",
             writes_seen, flagged_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
